>>> rtl/core/mpt_pkg.sv
// shared types, codes and reset values for the mouse position tracker
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned PosWidth   = 16;
   localparam int unsigned CsrIndexWidth = 2;

   // event kinds
   localparam logic EV_MOVE   = 1'b0;
   localparam logic EV_BUTTON = 1'b1;

   // button change codes
   localparam logic [1:0] CHG_NONE    = 2'd0;
   localparam logic [1:0] CHG_PRESS   = 2'd1;
   localparam logic [1:0] CHG_RELEASE = 2'd2;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_LEFT   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_RIGHT  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_TOP    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_BOTTOM = 2'd3;

   localparam logic signed [PosWidth-1:0] RESET_WINDOW_LEFT   = 16'sd0;
   localparam logic signed [PosWidth-1:0] RESET_WINDOW_RIGHT  = 16'sd319;
   localparam logic signed [PosWidth-1:0] RESET_WINDOW_TOP    = 16'sd0;
   localparam logic signed [PosWidth-1:0] RESET_WINDOW_BOTTOM = 16'sd255;

   typedef struct packed {
      logic [15:0] counter_word;
      logic        left_line;
      logic        right_line;
   } req_type;

   typedef struct packed {
      logic               event_kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [7:0]  delta_x;
      logic signed [7:0]  delta_y;
      logic [1:0]         left_change;
      logic [1:0]         right_change;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] top;
      logic signed [15:0] bottom;
   } window_type;

   typedef struct packed {
      logic [7:0]         prev_x;
      logic [7:0]         prev_y;
      logic [1:0]         buttons;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               primed;
   } track_type;

   // events produced by one request, move first
   typedef struct packed {
      logic               move_pend;
      logic               button_pend;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [7:0]  delta_x;
      logic signed [7:0]  delta_y;
      logic [1:0]         left_change;
      logic [1:0]         right_change;
   } pair_type;

endpackage

`default_nettype wire

>>> rtl/core/mpt_step.sv
// per-request update: deltas, clamped positions, button changes
`timescale 1ns / 1ps
`default_nettype none

module mpt_step (
   input  var mpt_pkg::track_type  track,
   input  var mpt_pkg::window_type window,
   input  var mpt_pkg::req_type    req,
   output mpt_pkg::track_type      track_next,
   output mpt_pkg::pair_type       pair
);

   logic [7:0]         count_x;
   logic [7:0]         count_y;
   logic [1:0]         btn;
   logic [1:0]         change;
   logic signed [7:0]  dx;
   logic signed [7:0]  dy;
   logic signed [15:0] new_x;
   logic signed [15:0] new_y;

   assign count_x = req.counter_word[7:0];
   assign count_y = req.counter_word[15:8];
   assign btn     = {~req.right_line, ~req.left_line};
   assign change  = track.buttons ^ btn;
   assign dx      = count_x - track.prev_x;
   assign dy      = count_y - track.prev_y;

   function automatic logic signed [15:0] clamp_move(
      input logic signed [15:0] pos,
      input logic signed [7:0]  delta,
      input logic signed [15:0] lo,
      input logic signed [15:0] hi
   );
      logic signed [16:0] sum;
      logic signed [16:0] raised;
      logic signed [16:0] lo_w;
      logic signed [16:0] hi_w;
      lo_w   = {lo[15], lo};
      hi_w   = {hi[15], hi};
      sum    = {pos[15], pos} + {{9{delta[7]}}, delta};
      raised = (sum < lo_w) ? lo_w : sum;
      clamp_move = (raised > hi_w) ? hi : raised[15:0];
   endfunction

   assign new_x = (dx != 8'sd0) ? clamp_move(track.pos_x, dx, window.left, window.right)
                                : track.pos_x;
   assign new_y = (dy != 8'sd0) ? clamp_move(track.pos_y, dy, window.top, window.bottom)
                                : track.pos_y;

   always_comb begin
      track_next.prev_x  = count_x;
      track_next.prev_y  = count_y;
      track_next.buttons = btn;
      track_next.primed  = 1'b1;
      pair.delta_x       = dx;
      pair.delta_y       = dy;
      pair.left_change   = mpt_pkg::CHG_NONE;
      pair.right_change  = mpt_pkg::CHG_NONE;
      if (change[0]) begin
         pair.left_change = btn[0] ? mpt_pkg::CHG_PRESS : mpt_pkg::CHG_RELEASE;
      end
      if (change[1]) begin
         pair.right_change = btn[1] ? mpt_pkg::CHG_PRESS : mpt_pkg::CHG_RELEASE;
      end
      if (!track.primed) begin
         // priming request only loads state
         track_next.pos_x = window.left;
         track_next.pos_y = window.top;
         pair.move_pend   = 1'b0;
         pair.button_pend = 1'b0;
      end else begin
         track_next.pos_x = new_x;
         track_next.pos_y = new_y;
         pair.move_pend   = (dx != 8'sd0) || (dy != 8'sd0);
         pair.button_pend = (change != 2'b00);
      end
      pair.pos_x = track_next.pos_x;
      pair.pos_y = track_next.pos_y;
   end

endmodule

`default_nettype wire

>>> rtl/core/mouse_position_tracker.sv
// a request's first result passes through the event pair register, then the output register
// a request with both a move and a button event holds off the next until its move is sent
// otherwise one per cycle if unstalled; the event pair and output registers set the rate
// reset: synchronous, window registers to defaults, tracker unprimed, no events pending
`timescale 1ns / 1ps
`default_nettype none

module mouse_position_tracker (
   input  var logic                clock,
   input  var logic                reset,
   input  var logic                req_valid,
   output logic                    req_stall,
   input  var mpt_pkg::req_type    req_data,
   output logic                    rsp_valid,
   input  var logic                rsp_stall,
   output mpt_pkg::rsp_type        rsp_data,
   input  var logic                csr_we,
   input  var logic [mpt_pkg::CsrIndexWidth-1:0] csr_index,
   input  var logic [15:0]         csr_wdata
);

   mpt_pkg::window_type window_ff, window_in;
   mpt_pkg::track_type  track_ff, track_in, track_step;
   mpt_pkg::pair_type   pair_ff, pair_in, pair_step;
   mpt_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                pop;
   logic                pair_empty_next;
   logic                req_accept;

   mpt_step u_step (
      .track      (track_ff),
      .window     (window_ff),
      .req        (req_data),
      .track_next (track_step),
      .pair       (pair_step)
   );

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign pop             = out_free && (pair_ff.move_pend || pair_ff.button_pend);
   assign pair_empty_next = !(pair_ff.move_pend || pair_ff.button_pend)
                            || (out_free && !(pair_ff.move_pend && pair_ff.button_pend));
   assign req_stall       = !pair_empty_next;
   assign req_accept      = req_valid && !req_stall;

   always_comb begin
      window_in = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            mpt_pkg::CSR_WINDOW_LEFT:   window_in.left   = csr_wdata;
            mpt_pkg::CSR_WINDOW_RIGHT:  window_in.right  = csr_wdata;
            mpt_pkg::CSR_WINDOW_TOP:    window_in.top    = csr_wdata;
            mpt_pkg::CSR_WINDOW_BOTTOM: window_in.bottom = csr_wdata;
            default: window_in = window_ff;
         endcase
      end
   end

   always_comb begin
      track_in     = req_accept ? track_step : track_ff;
      pair_in      = pair_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pos_x        = pair_ff.pos_x;
         rsp_in.pos_y        = pair_ff.pos_y;
         rsp_in.delta_x      = pair_ff.delta_x;
         rsp_in.delta_y      = pair_ff.delta_y;
         if (pair_ff.move_pend) begin
            rsp_in.event_kind   = mpt_pkg::EV_MOVE;
            rsp_in.left_change  = mpt_pkg::CHG_NONE;
            rsp_in.right_change = mpt_pkg::CHG_NONE;
            rsp_in.last         = !pair_ff.button_pend;
            pair_in.move_pend   = 1'b0;
         end else begin
            rsp_in.event_kind   = mpt_pkg::EV_BUTTON;
            rsp_in.left_change  = pair_ff.left_change;
            rsp_in.right_change = pair_ff.right_change;
            rsp_in.last         = 1'b1;
            pair_in.button_pend = 1'b0;
         end
      end
      if (req_accept) begin
         pair_in = pair_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.left   <= mpt_pkg::RESET_WINDOW_LEFT;
         window_ff.right  <= mpt_pkg::RESET_WINDOW_RIGHT;
         window_ff.top    <= mpt_pkg::RESET_WINDOW_TOP;
         window_ff.bottom <= mpt_pkg::RESET_WINDOW_BOTTOM;
         track_ff         <= '0;
         pair_ff.move_pend   <= 1'b0;
         pair_ff.button_pend <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         window_ff        <= window_in;
         track_ff         <= track_in;
         pair_ff.move_pend   <= pair_in.move_pend;
         pair_ff.button_pend <= pair_in.button_pend;
         rsp_valid_ff     <= rsp_valid_in;
      end
      pair_ff.pos_x        <= pair_in.pos_x;
      pair_ff.pos_y        <= pair_in.pos_y;
      pair_ff.delta_x      <= pair_in.delta_x;
      pair_ff.delta_y      <= pair_in.delta_y;
      pair_ff.left_change  <= pair_in.left_change;
      pair_ff.right_change <= pair_in.right_change;
   end

   always_ff @(posedge clock) begin
      rsp_ff               <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a move event always carries a nonzero delta
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_kind == mpt_pkg::EV_MOVE)
         |-> (rsp_ff.delta_x != 8'sd0 || rsp_ff.delta_y != 8'sd0))
      else $error("move event without motion");

   // a button event always reports some change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_kind == mpt_pkg::EV_BUTTON)
         |-> (rsp_ff.left_change != mpt_pkg::CHG_NONE
              || rsp_ff.right_change != mpt_pkg::CHG_NONE))
      else $error("button event without change");

   // a new request never lands on a pair still holding two events
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(pair_ff.move_pend && pair_ff.button_pend))
      else $error("request accepted over pending events");

   // a move event that is not last is followed by its button event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !rsp_ff.last) |=> (pair_ff.button_pend
         || (rsp_valid_ff && rsp_ff.event_kind == mpt_pkg::EV_BUTTON)))
      else $error("button event lost after move event");

endmodule

`default_nettype wire
